[rtl/bpmf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpmf_pkg;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int OFFSET_W  = 48;
    localparam int LEN_W     = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // the pattern registers always hold sixteen bytes
    localparam int PAT_BYTES = 16;
    localparam int PAT_IDX_W = 4;

    // input tdata: data_byte then base_offset, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2
    } cfg_index_t;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

[rtl/byte_pattern_match_finder.sv]
`timescale 1ns / 1ps
`default_nettype none
// a match appears on m_tvalid in the cycle after the byte that completes it is accepted
// one byte per cycle while unstalled, set by the single window compare and the offset adder
// a byte is taken whenever the output register is empty or is being drained in that cycle
// reset (rst_n low, asynchronous) clears the window, counters, offset, pattern registers
// and the output valid; no clearing pass is needed

module byte_pattern_match_finder #(
    parameter int MAX_PATTERN = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,

    // configuration write channel
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [bpmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [bpmf_pkg::CFG_W-1:0]         cfg_data,

    // byte stream in
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [bpmf_pkg::S_TDATA_W-1:0]     s_tdata,   // data_byte[7:0], base_offset[55:8]
    input  wire                                s_tuser,   // first_byte[0]

    // match offsets out
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [bpmf_pkg::M_TDATA_W-1:0]     m_tdata    // match_offset[47:0]
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    // configuration registers
    logic [bpmf_pkg::CFG_W-1:0]  pat_low_reg;
    logic [bpmf_pkg::CFG_W-1:0]  pat_high_reg;
    logic [bpmf_pkg::LEN_W-1:0]  pat_len_reg;

    // search state
    bpmf_pkg::byte_t               recent_reg [MAX_PATTERN];
    bpmf_pkg::byte_t               window_next [MAX_PATTERN];
    logic [CNT_W-1:0]              seen_reg, seen_next;
    logic [CNT_W-1:0]              suppress_reg, suppress_next;
    logic [bpmf_pkg::OFFSET_W-1:0] cur_offset_reg, cur_offset_next;

    // output register
    logic                          out_valid_reg;
    logic [bpmf_pkg::OFFSET_W-1:0] out_offset_reg;

    // unpacked stream fields
    bpmf_pkg::byte_t               in_byte;
    logic                          in_first;
    logic [bpmf_pkg::OFFSET_W-1:0] in_base;

    logic                          in_accept;
    logic                          cfg_accept;

    bpmf_pkg::byte_t               pat_bytes [bpmf_pkg::PAT_BYTES];
    logic [bpmf_pkg::LEN_W-1:0]    eff_len;
    logic [bpmf_pkg::LEN_W-1:0]    lane_idx [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]        lane_ok;
    logic                          blocked;
    logic                          hit;
    logic [bpmf_pkg::OFFSET_W-1:0] here;
    logic [bpmf_pkg::OFFSET_W-1:0] match_offset;

    assign in_byte  = s_tdata[bpmf_pkg::BYTE_W-1:0];
    assign in_base  = s_tdata[bpmf_pkg::BYTE_W +: bpmf_pkg::OFFSET_W];
    assign in_first = s_tuser;

    // configuration is always taken
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // the output register is the skid point: accept while it is empty or draining
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;

    // length above the window saturates
    always_comb
    begin
        if (pat_len_reg > bpmf_pkg::LEN_W'(MAX_PATTERN))
            eff_len = bpmf_pkg::LEN_W'(MAX_PATTERN);
        else
            eff_len = pat_len_reg;
    end

    always_comb
    begin
        for (int b = 0; b < bpmf_pkg::PAT_BYTES / 2; b++)
        begin
            pat_bytes[b]     = pat_low_reg[b*bpmf_pkg::BYTE_W +: bpmf_pkg::BYTE_W];
            pat_bytes[b + 8] = pat_high_reg[b*bpmf_pkg::BYTE_W +: bpmf_pkg::BYTE_W];
        end
    end

    // shifted window, newest byte in lane 0; a first byte clears the older lanes
    always_comb
    begin
        window_next[0] = in_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
            window_next[k] = in_first ? '0 : recent_reg[k-1];
    end

    // byte count saturates at the window depth
    always_comb
    begin
        if (in_first)
            seen_next = CNT_W'(1);
        else if (seen_reg < CNT_W'(MAX_PATTERN))
            seen_next = seen_reg + CNT_W'(1);
        else
            seen_next = seen_reg;
    end

    // lane j holds the byte that must equal pattern byte eff_len-1-j
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            lane_idx[j] = eff_len - bpmf_pkg::LEN_W'(1) - bpmf_pkg::LEN_W'(j);
            lane_ok[j]  = (bpmf_pkg::LEN_W'(j) >= eff_len) ||
                          (window_next[j] == pat_bytes[lane_idx[j][bpmf_pkg::PAT_IDX_W-1:0]]);
        end
    end

    assign blocked = !in_first && (suppress_reg != '0);

    assign hit = (eff_len != '0) &&
                 (bpmf_pkg::LEN_W'(seen_next) >= eff_len) &&
                 !blocked &&
                 (&lane_ok);

    // offset of this byte; the match starts eff_len-1 bytes earlier
    assign here            = in_first ? in_base : cur_offset_reg;
    assign cur_offset_next = here + bpmf_pkg::OFFSET_W'(1);
    assign match_offset    = cur_offset_next - bpmf_pkg::OFFSET_W'(eff_len);

    // non-overlapping: a match holds off the next eff_len-1 completions
    always_comb
    begin
        if (hit)
            suppress_next = CNT_W'(eff_len - bpmf_pkg::LEN_W'(1));
        else if (blocked)
            suppress_next = suppress_reg - CNT_W'(1);
        else
            suppress_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg_accept)
        begin
            case (bpmf_pkg::cfg_index_t'(cfg_index))
                bpmf_pkg::CFG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                bpmf_pkg::CFG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                bpmf_pkg::CFG_PATTERN_LEN:  pat_len_reg  <= cfg_data[bpmf_pkg::LEN_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
                recent_reg[k] <= '0;
            seen_reg       <= '0;
            suppress_reg   <= '0;
            cur_offset_reg <= '0;
        end
        else if (in_accept)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
                recent_reg[k] <= window_next[k];
            seen_reg       <= seen_next;
            suppress_reg   <= suppress_next;
            cur_offset_reg <= cur_offset_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= hit;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && hit)
            out_offset_reg <= match_offset;
    end

    // a completed match is always presented on the next cycle
    a_hit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && hit) |=> (m_tvalid && (m_tdata == $past(match_offset))))
        else $error("accepted match not presented");

    // a new buffer restarts the count and drops any hold-off
    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_first) |=> (seen_reg == CNT_W'(1) && suppress_reg == '0))
        else $error("first byte did not restart the buffer state");

    // the count never passes the window depth and the hold-off stays below it
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg <= CNT_W'(MAX_PATTERN)) && (suppress_reg < CNT_W'(MAX_PATTERN)))
        else $error("counter out of range");

    // the offset advances by exactly one per accepted byte without a first byte
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !in_first) |=>
            (cur_offset_reg == $past(cur_offset_reg) + bpmf_pkg::OFFSET_W'(1)))
        else $error("offset did not advance by one");

endmodule

`default_nettype wire
